// ----- design/nec_irtx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nec_irtx_pkg;

  // Widths fixed by the request and result formats.
  localparam int ACTION_W     = 2;
  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 32;
  localparam int MAX_FRAME_W  = 64;
  localparam int HALF_W       = 16;
  localparam int CYCLE_W      = 12;

  // Configuration port.
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_OFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_ON       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd6;

  localparam logic [HALF_W-1:0]  RST_CARRIER_HALF = 16'd13;
  localparam logic [CYCLE_W-1:0] RST_LEADER_ON    = 12'd342;
  localparam logic [CYCLE_W-1:0] RST_LEADER_OFF   = 12'd171;
  localparam logic [CYCLE_W-1:0] RST_REPEAT_OFF   = 12'd85;
  localparam logic [CYCLE_W-1:0] RST_BIT_ON       = 12'd21;
  localparam logic [CYCLE_W-1:0] RST_ONE_SPACE    = 12'd64;
  localparam logic [CYCLE_W-1:0] RST_ZERO_SPACE   = 12'd21;

  // Request action codes.
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FRAME  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REPEAT = 2'd2;

  // Defaults for the top-level parameters.
  localparam int FRAME_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   address_byte;
    logic [BYTE_W-1:0]   command_byte;
  } in_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic done_res;
  } out_t;

  // Classified request as it sits in the queue.
  typedef struct packed {
    logic              start;
    logic              repeat_code;
    logic [WORD_W-1:0] word;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- design/nec_irtx_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nec_irtx_front (
  input  nec_irtx_pkg::in_t    req_i,
  output nec_irtx_pkg::entry_t entry_o
);
  import nec_irtx_pkg::*;

  // Codes other than frame and repeat are plain ticks.
  always_comb begin
    entry_o.start       = (req_i.action == ACT_FRAME) || (req_i.action == ACT_REPEAT);
    entry_o.repeat_code = (req_i.action == ACT_REPEAT);
    entry_o.word        = {~req_i.command_byte, req_i.command_byte,
                           ~req_i.address_byte, req_i.address_byte};
  end

endmodule

`default_nettype wire

// ----- design/nec_irtx_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nec_irtx_queue #(
  parameter int DEPTH = nec_irtx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  nec_irtx_pkg::entry_t  push_data_i,
  input  logic                  pop_i,
  output nec_irtx_pkg::entry_t  pop_data_o,
  output nec_irtx_pkg::q_stat_t stat_o
);
  import nec_irtx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_r == CNT_W'(DEPTH));
  assign stat_o.empty = (count_r == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/nec_irtx_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nec_irtx_back #(
  parameter int FRAME_BITS = nec_irtx_pkg::FRAME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [nec_irtx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nec_irtx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  nec_irtx_pkg::entry_t                 entry_i,
  input  nec_irtx_pkg::q_stat_t                q_stat_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output nec_irtx_pkg::out_t                   out_data_o
);
  import nec_irtx_pkg::*;

  localparam int BC_W = $clog2(FRAME_BITS);

  localparam logic [2:0] SEG_IDLE     = 3'd0;
  localparam logic [2:0] SEG_LEAD_ON  = 3'd1;
  localparam logic [2:0] SEG_LEAD_OFF = 3'd2;
  localparam logic [2:0] SEG_BIT_ON   = 3'd3;
  localparam logic [2:0] SEG_BIT_OFF  = 3'd4;
  localparam logic [2:0] SEG_REP_OFF  = 3'd5;
  localparam logic [2:0] SEG_END_ON   = 3'd6;

  // Configuration registers.
  logic [HALF_W-1:0]  half_r;
  logic [CYCLE_W-1:0] lead_on_r, lead_off_r, rep_off_r, bit_on_r, one_sp_r, zero_sp_r;

  // Waveform state.
  logic [2:0]            seg_r, seg_nxt;
  logic [BC_W-1:0]       bc_r, bc_nxt;
  logic [FRAME_BITS-1:0] fs_r, fs_nxt;
  logic [CYCLE_W-1:0]    cc_r, cc_nxt;
  logic [HALF_W-1:0]     hp_r, hp_nxt;
  logic                  ph_r, ph_nxt;
  logic                  rm_r, rm_nxt;

  logic                  out_valid_r;
  out_t                  out_data_r, out_data_nxt;

  logic [MAX_FRAME_W-1:0] word_ext;

  assign word_ext    = {{(MAX_FRAME_W - WORD_W){1'b0}}, entry_i.word};
  assign pop_o       = !q_stat_i.empty && (!out_valid_r || out_ready_i);
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  always_comb begin
    logic [CYCLE_W-1:0] seg_len;
    logic               burst;

    seg_nxt      = seg_r;
    bc_nxt       = bc_r;
    fs_nxt       = fs_r;
    cc_nxt       = cc_r;
    hp_nxt       = hp_r;
    ph_nxt       = ph_r;
    rm_nxt       = rm_r;
    out_data_nxt = '0;
    seg_len      = bit_on_r;
    burst        = 1'b0;

    if (pop_o) begin
      // A start request only counts while nothing is being sent.
      if (seg_r == SEG_IDLE && entry_i.start) begin
        seg_nxt = SEG_LEAD_ON;
        rm_nxt  = entry_i.repeat_code;
        fs_nxt  = word_ext[FRAME_BITS-1:0];
        bc_nxt  = '0;
        cc_nxt  = '0;
        hp_nxt  = '0;
        ph_nxt  = 1'b0;
      end

      if (seg_nxt != SEG_IDLE) begin
        burst = seg_nxt inside {SEG_LEAD_ON, SEG_BIT_ON, SEG_END_ON};
        out_data_nxt.busy_res = 1'b1;
        out_data_nxt.ir_level = burst && !ph_nxt;

        case (seg_nxt)
          SEG_LEAD_ON:  seg_len = lead_on_r;
          SEG_LEAD_OFF: seg_len = lead_off_r;
          SEG_REP_OFF:  seg_len = rep_off_r;
          SEG_BIT_OFF:  seg_len = fs_nxt[0] ? one_sp_r : zero_sp_r;
          default:      seg_len = bit_on_r;
        endcase

        if ({1'b0, hp_nxt} + 17'd1 >= {1'b0, half_r}) begin
          hp_nxt = '0;
          if (!ph_nxt) begin
            ph_nxt = 1'b1;
          end else begin
            ph_nxt = 1'b0;
            if ({1'b0, cc_nxt} + 13'd1 >= {1'b0, seg_len}) begin
              cc_nxt = '0;
              case (seg_nxt)
                SEG_LEAD_ON:  seg_nxt = rm_nxt ? SEG_REP_OFF : SEG_LEAD_OFF;
                SEG_LEAD_OFF: seg_nxt = SEG_BIT_ON;
                SEG_BIT_ON:   seg_nxt = SEG_BIT_OFF;
                SEG_BIT_OFF: begin
                  fs_nxt = fs_nxt >> 1;
                  if (bc_nxt == BC_W'(FRAME_BITS - 1)) begin
                    bc_nxt  = '0;
                    seg_nxt = SEG_END_ON;
                  end else begin
                    bc_nxt  = bc_nxt + 1'b1;
                    seg_nxt = SEG_BIT_ON;
                  end
                end
                SEG_REP_OFF:  seg_nxt = SEG_END_ON;
                default: begin
                  seg_nxt = SEG_IDLE;
                  out_data_nxt.done_res = 1'b1;
                end
              endcase
            end else begin
              cc_nxt = cc_nxt + 1'b1;
            end
          end
        end else begin
          hp_nxt = hp_nxt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= RST_CARRIER_HALF;
      lead_on_r   <= RST_LEADER_ON;
      lead_off_r  <= RST_LEADER_OFF;
      rep_off_r   <= RST_REPEAT_OFF;
      bit_on_r    <= RST_BIT_ON;
      one_sp_r    <= RST_ONE_SPACE;
      zero_sp_r   <= RST_ZERO_SPACE;
      seg_r       <= SEG_IDLE;
      bc_r        <= '0;
      fs_r        <= '0;
      cc_r        <= '0;
      hp_r        <= '0;
      ph_r        <= 1'b0;
      rm_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CARRIER_HALF: half_r     <= cfg_wdata;
          CFG_LEADER_ON:    lead_on_r  <= cfg_wdata[CYCLE_W-1:0];
          CFG_LEADER_OFF:   lead_off_r <= cfg_wdata[CYCLE_W-1:0];
          CFG_REPEAT_OFF:   rep_off_r  <= cfg_wdata[CYCLE_W-1:0];
          CFG_BIT_ON:       bit_on_r   <= cfg_wdata[CYCLE_W-1:0];
          CFG_ONE_SPACE:    one_sp_r   <= cfg_wdata[CYCLE_W-1:0];
          CFG_ZERO_SPACE:   zero_sp_r  <= cfg_wdata[CYCLE_W-1:0];
          default: ;
        endcase
      end
      seg_r <= seg_nxt;
      bc_r  <= bc_nxt;
      fs_r  <= fs_nxt;
      cc_r  <= cc_nxt;
      hp_r  <= hp_nxt;
      ph_r  <= ph_nxt;
      rm_r  <= rm_nxt;
      if (pop_o) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/nec_ir_frame_transmitter_top.sv -----
// NEC infrared remote transmitter. Every request on the in_ channel is one
// sample tick of the output waveform; every tick yields exactly one result
// on the out_ channel carrying the IR level, a busy flag and a done flag.
// A request with action "frame" sent while idle starts a leader burst, a
// leader space, FRAME_BITS data bits (address, inverted address, command,
// inverted command, LSB first) and a closing burst. Action "repeat" sends a
// leader burst, a repeat space and the closing burst. Requests that start a
// transmission while one is running are treated as plain ticks.
// The front end classifies each request and pushes it into a short queue;
// the waveform engine pops one entry per cycle into the output register
// while that register is empty or being read by the receiver. An accepted
// request is first written into the queue; the engine then pops it and
// registers its result, which raises out_valid. Throughput is one request
// per cycle as long as the receiver keeps taking results.
// When the receiver stalls, the result holds in the output register, the
// queue fills and in_ready drops once the queue is full.
// Synchronous reset empties the queue and clears out_valid, returns the
// engine to idle and loads the default timing registers. Configuration
// writes on cfg_ take effect at the next edge and belong to idle periods.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_transmitter_top #(
  parameter int FRAME_BITS  = nec_irtx_pkg::FRAME_BITS_DEF,
  parameter int QUEUE_DEPTH = nec_irtx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  nec_irtx_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output nec_irtx_pkg::out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [nec_irtx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nec_irtx_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nec_irtx_pkg::*;

  entry_t  front_entry;
  entry_t  queue_entry;
  q_stat_t q_stat;
  logic    pop;

  // The queue accepts a request whenever it has room.
  assign in_ready = !q_stat.full;

  nec_irtx_front u_front (
    .req_i   (in_data),
    .entry_o (front_entry)
  );

  nec_irtx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_valid),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .pop_data_o  (queue_entry),
    .stat_o      (q_stat)
  );

  nec_irtx_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .entry_i     (queue_entry),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // The engine only pops from a queue that holds something.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("engine popped an empty queue");

  // The queue can never report full and empty together.
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // Done and a high IR level only happen inside a transmission.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_res || out_data.ir_level) |-> out_data.busy_res)
    else $error("done or IR level without busy");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

`default_nettype wire
